@@ rtl/mhe_pkg.sv @@
// ----------------------------------------------------------------------------
// mhe_pkg
// Shared types and codes for the MessagePack header encoder.
// ----------------------------------------------------------------------------
package mhe_pkg;

   // operation codes
   localparam logic [2:0] OP_UINT   = 3'd0;
   localparam logic [2:0] OP_NIL    = 3'd1;
   localparam logic [2:0] OP_BOOL   = 3'd2;
   localparam logic [2:0] OP_MAP    = 3'd3;
   localparam logic [2:0] OP_ARRAY  = 3'd4;
   localparam logic [2:0] OP_STRING = 3'd5;
   localparam logic [2:0] OP_BYTE   = 3'd6;

   // type bytes
   localparam logic [7:0] FIXMAP_BASE   = 8'h80;
   localparam logic [7:0] FIXARRAY_BASE = 8'h90;
   localparam logic [7:0] FIXSTR_BASE   = 8'ha0;
   localparam logic [7:0] NIL_CODE      = 8'hc0;
   localparam logic [7:0] FALSE_CODE    = 8'hc2;
   localparam logic [7:0] TRUE_CODE     = 8'hc3;
   localparam logic [7:0] UINT8_CODE    = 8'hcc;
   localparam logic [7:0] UINT16_CODE   = 8'hcd;
   localparam logic [7:0] UINT32_CODE   = 8'hce;
   localparam logic [7:0] STR8_CODE     = 8'hd9;
   localparam logic [7:0] STR16_CODE    = 8'hda;
   localparam logic [7:0] STR32_CODE    = 8'hdb;
   localparam logic [7:0] ARRAY16_CODE  = 8'hdc;
   localparam logic [7:0] ARRAY32_CODE  = 8'hdd;
   localparam logic [7:0] MAP16_CODE    = 8'hde;
   localparam logic [7:0] MAP32_CODE    = 8'hdf;

   // number of value bytes after the type byte
   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_8    = 3'd1;
   localparam logic [2:0] LEN_16   = 3'd2;
   localparam logic [2:0] LEN_32   = 3'd4;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // one classified request
   typedef struct packed {
      logic [7:0]  type_byte;
      logic [31:0] value;
      logic [2:0]  nbytes;
   } entry_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

@@ rtl/mhe_front.sv @@
// ----------------------------------------------------------------------------
// mhe_front
// Classifies a request into a type byte and a count of big-endian value bytes.
// ----------------------------------------------------------------------------
module mhe_front (
   input  logic              req_valid,
   input  logic [2:0]        req_op,
   input  logic [31:0]       req_value,
   output logic              push,
   output mhe_pkg::entry_type entry
);

   logic le_ff8;
   logic le_ffff;

   assign le_ff8  = (req_value[31:8] == 24'd0);
   assign le_ffff = (req_value[31:16] == 16'd0);

   always_comb begin
      entry.value     = req_value;
      entry.type_byte = mhe_pkg::NIL_CODE;
      entry.nbytes    = mhe_pkg::LEN_NONE;
      push            = req_valid;
      unique case (req_op) inside
         mhe_pkg::OP_UINT: begin
            if (req_value[31:7] == 25'd0) begin
               entry.type_byte = req_value[7:0];
            end else if (le_ff8) begin
               entry.type_byte = mhe_pkg::UINT8_CODE;
               entry.nbytes    = mhe_pkg::LEN_8;
            end else if (le_ffff) begin
               entry.type_byte = mhe_pkg::UINT16_CODE;
               entry.nbytes    = mhe_pkg::LEN_16;
            end else begin
               entry.type_byte = mhe_pkg::UINT32_CODE;
               entry.nbytes    = mhe_pkg::LEN_32;
            end
         end
         mhe_pkg::OP_NIL: begin
            entry.type_byte = mhe_pkg::NIL_CODE;
         end
         mhe_pkg::OP_BOOL: begin
            entry.type_byte = (req_value != 32'd0) ? mhe_pkg::TRUE_CODE
                                                   : mhe_pkg::FALSE_CODE;
         end
         mhe_pkg::OP_MAP, mhe_pkg::OP_ARRAY: begin
            if (req_value[31:4] == 28'd0) begin
               entry.type_byte = ((req_op == mhe_pkg::OP_MAP) ? mhe_pkg::FIXMAP_BASE
                                                              : mhe_pkg::FIXARRAY_BASE)
                                 | {4'd0, req_value[3:0]};
            end else if (le_ffff) begin
               entry.type_byte = (req_op == mhe_pkg::OP_MAP) ? mhe_pkg::MAP16_CODE
                                                             : mhe_pkg::ARRAY16_CODE;
               entry.nbytes    = mhe_pkg::LEN_16;
            end else begin
               entry.type_byte = (req_op == mhe_pkg::OP_MAP) ? mhe_pkg::MAP32_CODE
                                                             : mhe_pkg::ARRAY32_CODE;
               entry.nbytes    = mhe_pkg::LEN_32;
            end
         end
         mhe_pkg::OP_STRING: begin
            if (req_value[31:5] == 27'd0) begin
               entry.type_byte = mhe_pkg::FIXSTR_BASE | {3'd0, req_value[4:0]};
            end else if (le_ff8) begin
               entry.type_byte = mhe_pkg::STR8_CODE;
               entry.nbytes    = mhe_pkg::LEN_8;
            end else if (le_ffff) begin
               entry.type_byte = mhe_pkg::STR16_CODE;
               entry.nbytes    = mhe_pkg::LEN_16;
            end else begin
               entry.type_byte = mhe_pkg::STR32_CODE;
               entry.nbytes    = mhe_pkg::LEN_32;
            end
         end
         mhe_pkg::OP_BYTE: begin
            entry.type_byte = req_value[7:0];
         end
         default: begin
            // unused op: swallowed, nothing queued
            push = 1'b0;
         end
      endcase
   end

endmodule

@@ rtl/mhe_queue.sv @@
// ----------------------------------------------------------------------------
// mhe_queue
// Small FIFO of classified requests between front and back end.
// ----------------------------------------------------------------------------
module mhe_queue #(
   parameter int DEPTH = mhe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mhe_pkg::entry_type push_entry,
   input  logic               pop,
   output logic               full,
   output mhe_pkg::head_type  head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

   mhe_pkg::entry_type slots_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign do_push    = push && !full;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/mhe_back.sv @@
// ----------------------------------------------------------------------------
// mhe_back
// Serializes the queue head into bytes: type byte, then value MSB first.
// ----------------------------------------------------------------------------
module mhe_back (
   input  logic              clock,
   input  logic              reset,
   input  mhe_pkg::head_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last
);

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       advance;
   logic       is_last;
   logic [1:0] sel;

   // output register free or being drained
   assign advance = !valid_ff || !rsp_stall;
   assign is_last = (idx_ff == head.entry.nbytes);
   // bytes still to go after this one, mod 4; picks the value byte
   assign sel     = head.entry.nbytes[1:0] - idx_ff[1:0];
   assign pop     = advance && head.valid && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (advance) begin
         valid_in = head.valid;
         last_in  = is_last;
         if (idx_ff == 3'd0) begin
            byte_in = head.entry.type_byte;
         end else begin
            byte_in = head.entry.value[{sel, 3'b000} +: 8];
         end
         if (head.valid) begin
            idx_in = is_last ? 3'd0 : idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;

endmodule

@@ rtl/msgpack_header_encoder.sv @@
// ----------------------------------------------------------------------------
// msgpack_header_encoder
// Encodes one request (op, 32-bit value) into MessagePack bytes, one per word.
// ----------------------------------------------------------------------------
//   channel  dir  handshake             payload
//   req_     in   req_valid/req_stall   req_op[2:0], req_value[31:0]
//   rsp_     out  rsp_valid/rsp_stall   rsp_out_byte[7:0], rsp_last
//
// An item yields 1 to 5 output words (type byte plus 0, 1, 2 or 4 value
// bytes); the back end's single output register emits one word per cycle
// while rsp_stall is low and the queue has an item. An accepted request
// goes to a queue slot, then the output register. An unused op is dropped.
// Reset is synchronous and empties the queue and the output register.
// req_stall is high only while the queue is full; rsp_stall freezes the
// output register and, through the queue, eventually the input.
// ----------------------------------------------------------------------------
module msgpack_header_encoder #(
   parameter int QUEUE_DEPTH = mhe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request words
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_value,
   // encoded byte words
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last
);

   mhe_pkg::entry_type front_entry;
   mhe_pkg::head_type  queue_head;
   logic               front_push;
   logic               queue_full;
   logic               back_pop;

   // front end: classify the request combinationally
   mhe_front u_front (
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_value (req_value),
      .push      (front_push),
      .entry     (front_entry)
   );

   // decoupling queue; stall the input only when it has no room
   mhe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_push),
      .push_entry (front_entry),
      .pop        (back_pop),
      .full       (queue_full),
      .head       (queue_head)
   );

   assign req_stall = queue_full;

   // back end: walk the head entry out byte by byte
   mhe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (queue_head),
      .pop          (back_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

@@ rtl/mhe_checker.sv @@
// ----------------------------------------------------------------------------
// mhe_checker
// Port-level assertions for the MessagePack header encoder.
// ----------------------------------------------------------------------------
module mhe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_last
);

   // reset empties the output and the queue
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("output or input stall not cleared by reset");

   // a stalled output word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last)))
      else $error("stalled output word changed");

   // a full queue means the back end is busy
   a_full_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled while output idle");

   // bytes of one item come out without gaps
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> rsp_valid)
      else $error("gap inside an encoded item");

endmodule

bind msgpack_header_encoder mhe_checker u_mhe_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_last     (rsp_last)
);
